@@ src/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg
// Shared widths and codes for the plane triangle stiffness pipeline.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // multiplier chunking, divider quotient width
    localparam int CHUNK_W = 32;
    localparam int QW      = 64;
    localparam int DIV_LAT = QW + 1;
    localparam int MUL_LAT = 3;

    // datapath widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int VEC_W   = 34;
    localparam int MAT_W   = 48;
    localparam int THICK_W = 32;
    localparam int DET_W   = 67;
    localparam int G_W     = 83;   // C * column of Bn
    localparam int K_W     = 118;  // Bn' * C * Bn entry
    localparam int N_W     = 151;  // thickness * entry
    localparam int NUM_W   = 152;  // magnitude plus rounding half
    localparam int ENTRY_W = 64;
    localparam int ROWS    = 6;

    localparam logic [2:0] ROW_LAST = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_THICK = 3'd0;
    localparam logic [2:0] CFG_C11   = 3'd1;
    localparam logic [2:0] CFG_C12   = 3'd2;
    localparam logic [2:0] CFG_C13   = 3'd3;
    localparam logic [2:0] CFG_C22   = 3'd4;
    localparam logic [2:0] CFG_C23   = 3'd5;
    localparam logic [2:0] CFG_C33   = 3'd6;

endpackage

@@ src/tes_smul.sv @@
// ----------------------------------------------------------------------------
// tes_smul
// Three-stage signed multiplier: magnitudes, 32x32 partial products, sum.
// ----------------------------------------------------------------------------
module tes_smul #(
    parameter int AW = 34,
    parameter int BW = 48
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int CW = tes_pkg::CHUNK_W;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int PW = AW + BW;
    localparam int SW = (NA + NB) * CW;

    logic [AW-1:0]      n_ma;
    logic [BW-1:0]      n_mb;
    logic [NA*CW-1:0]   r_ma;
    logic [NB*CW-1:0]   r_mb;
    logic               r_neg1;
    logic               r_neg2;
    logic [2*CW-1:0]    r_pp [NA][NB];
    logic [SW-1:0]      n_sum;
    logic [PW-1:0]      n_mag;
    logic signed [PW-1:0] r_p;

    assign n_ma = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign n_mb = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= (NA*CW)'(n_ma);
            r_mb   <= (NB*CW)'(n_mb);
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
            r_neg2 <= r_neg1;
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_ma[i*CW +: CW] * r_mb[j*CW +: CW];
                end
            end
            r_p <= r_neg2 ? -$signed(n_mag) : $signed(n_mag);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (SW'(r_pp[i][j]) << (CW * (i + j)));
            end
        end
    end

    assign n_mag = n_sum[PW-1:0];
    assign o_p   = r_p;

endmodule

@@ src/tes_div.sv @@
// ----------------------------------------------------------------------------
// tes_div
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// ----------------------------------------------------------------------------
module tes_div #(
    parameter int DENW = 84,
    parameter int NUMW = 152
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [NUMW-1:0]         i_num,
    input  logic [DENW-1:0]         i_den,
    output logic [tes_pkg::QW-1:0]  o_q,
    output logic                    o_ovf
);
    localparam int QW   = tes_pkg::QW;
    localparam int HW   = NUMW - QW;
    localparam int CMPW = (HW > DENW) ? HW : DENW;

    logic [DENW-1:0] r_rem [QW+1];
    logic [DENW-1:0] r_den [QW+1];
    logic [QW-1:0]   r_low [QW+1];
    logic            r_ovf [QW+1];

    // entry: upper dividend bits must stay below the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DENW'(i_num[NUMW-1:QW]);
            r_low[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= CMPW'(i_num[NUMW-1:QW]) >= CMPW'(i_den);
        end
    end

    // quotient bits shift into the low word as dividend bits leave it
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DENW:0] rem_sh;
        logic [DENW:0] diff;
        logic          ge;

        assign rem_sh = {r_rem[k-1], r_low[k-1][QW-1]};
        assign diff   = rem_sh - {1'b0, r_den[k-1]};
        assign ge     = rem_sh >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DENW-1:0] : rem_sh[DENW-1:0];
                r_low[k] <= {r_low[k-1][QW-2:0], ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_q   = r_low[QW];
    assign o_ovf = r_ovf[QW];

endmodule

@@ src/triangle_element_stiffness_core.sv @@
// ----------------------------------------------------------------------------
// triangle_element_stiffness_core
// Rows pass the row sequencer, stages 1 to 5, the multiply groups, the divider
// lanes and the output register. One matrix row per cycle unless the output
// stalls; the row sequencer, which takes a new triangle at its last row, sets it.
// Reset (synchronous, active low) empties the pipeline and loads the
// thickness and material registers with their defaults.
// ----------------------------------------------------------------------------
module triangle_element_stiffness_core #(
    parameter int FRAC_BITS = tes_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input beat
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: first_x, first_y, second_x, second_y, third_x, third_y (32 each)
    input  logic [191:0] i_s_tdata,
    // output beat
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: entry_col0 .. entry_col5 (64 each)
    output logic [383:0] o_m_tdata,
    // tuser: row_index [2:0], degenerate [3]
    output logic [3:0]   o_m_tuser,
    output logic         o_m_tlast,
    // configuration
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [47:0]  i_cfg_wdata
);
    localparam int CW_  = tes_pkg::COORD_W;
    localparam int DW   = tes_pkg::DIFF_W;
    localparam int VW   = tes_pkg::VEC_W;
    localparam int MW   = tes_pkg::MAT_W;
    localparam int TW   = tes_pkg::THICK_W;
    localparam int DETW = tes_pkg::DET_W;
    localparam int GW   = tes_pkg::G_W;
    localparam int KW   = tes_pkg::K_W;
    localparam int NW   = tes_pkg::N_W;
    localparam int UW   = tes_pkg::NUM_W;
    localparam int EW   = tes_pkg::ENTRY_W;
    localparam int ML   = tes_pkg::MUL_LAT;
    localparam int DL   = tes_pkg::DIV_LAT;
    localparam int DENW = DETW + FRAC_BITS + 1;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             row;
        logic [2:0][VW-1:0]     pv;
        logic [2:0][VW-1:0]     uv;
    } t_m1;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             row;
        logic signed [DETW-1:0] det;
    } t_m2;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             row;
        logic                   zero;
        logic [DETW-1:0]        absd;
    } t_m3;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             row;
        logic                   zero;
        logic [5:0]             neg;
    } t_md;

    // whole pipeline advances when the output register is free or drains
    logic en;
    logic s_acc;

    // ---------------- configuration registers ----------------
    logic [TW-1:0]        r_thick;
    logic signed [MW-1:0] r_mat [6];   // c11 c12 c13 c22 c23 c33

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thick  <= TW'(65536);
            r_mat[0] <= MW'(65536);
            r_mat[1] <= '0;
            r_mat[2] <= '0;
            r_mat[3] <= MW'(65536);
            r_mat[4] <= '0;
            r_mat[5] <= MW'(32768);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tes_pkg::CFG_THICK: r_thick  <= i_cfg_wdata[TW-1:0];
                tes_pkg::CFG_C11:   r_mat[0] <= i_cfg_wdata;
                tes_pkg::CFG_C12:   r_mat[1] <= i_cfg_wdata;
                tes_pkg::CFG_C13:   r_mat[2] <= i_cfg_wdata;
                tes_pkg::CFG_C22:   r_mat[3] <= i_cfg_wdata;
                tes_pkg::CFG_C23:   r_mat[4] <= i_cfg_wdata;
                tes_pkg::CFG_C33:   r_mat[5] <= i_cfg_wdata;
                default: ;          // unused index, write dropped
            endcase
        end
    end

    // ---------------- row sequencer ----------------
    // Holds the corner differences of one triangle and walks rows 0..5.
    logic                  r_sq_valid;
    logic [2:0]            r_sq_row;
    logic signed [DW-1:0]  r_sq_a, r_sq_b, r_sq_c, r_sq_d;
    logic signed [CW_-1:0] x1, y1, x2, y2, x3, y3;

    assign x1 = i_s_tdata[0*CW_ +: CW_];
    assign y1 = i_s_tdata[1*CW_ +: CW_];
    assign x2 = i_s_tdata[2*CW_ +: CW_];
    assign y2 = i_s_tdata[3*CW_ +: CW_];
    assign x3 = i_s_tdata[4*CW_ +: CW_];
    assign y3 = i_s_tdata[5*CW_ +: CW_];

    assign o_s_tready = en && (!r_sq_valid || r_sq_row == tes_pkg::ROW_LAST);
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
            r_sq_row   <= '0;
        end else if (en) begin
            if (r_sq_valid && r_sq_row != tes_pkg::ROW_LAST) begin
                r_sq_row <= 3'(r_sq_row + 3'd1);
            end else if (s_acc) begin
                r_sq_valid <= 1'b1;
                r_sq_row   <= '0;
                r_sq_a     <= DW'(x2) - DW'(x1);
                r_sq_b     <= DW'(y2) - DW'(y1);
                r_sq_c     <= DW'(x3) - DW'(x1);
                r_sq_d     <= DW'(y3) - DW'(y1);
            end else begin
                r_sq_valid <= 1'b0;
            end
        end
    end

    // Bn columns: even col 2k = (P[k], 0, U[k]), odd col 2k+1 = (0, U[k], P[k])
    logic signed [VW-1:0] pv [3];
    logic signed [VW-1:0] uv [3];
    logic signed [VW-1:0] sel_s, sel_t;
    logic signed [MW-1:0] cm [3][3];
    logic signed [MW-1:0] sel_ga [3];
    logic signed [MW-1:0] sel_gb [3];

    assign pv[0] = VW'(r_sq_b) - VW'(r_sq_d);
    assign pv[1] = VW'(r_sq_d);
    assign pv[2] = -VW'(r_sq_b);
    assign uv[0] = VW'(r_sq_c) - VW'(r_sq_a);
    assign uv[1] = -VW'(r_sq_c);
    assign uv[2] = VW'(r_sq_a);

    always_comb begin
        unique case (r_sq_row[2:1])
            2'd1:    begin sel_s = pv[1]; sel_t = uv[1]; end
            2'd2:    begin sel_s = pv[2]; sel_t = uv[2]; end
            default: begin sel_s = pv[0]; sel_t = uv[0]; end
        endcase
    end

    // symmetric material matrix
    assign cm[0][0] = r_mat[0]; assign cm[0][1] = r_mat[1]; assign cm[0][2] = r_mat[2];
    assign cm[1][0] = r_mat[1]; assign cm[1][1] = r_mat[3]; assign cm[1][2] = r_mat[4];
    assign cm[2][0] = r_mat[2]; assign cm[2][1] = r_mat[4]; assign cm[2][2] = r_mat[5];

    // g = C * e: even row  g_k = C[k][0]*s + C[k][2]*t
    //            odd row   g_k = C[k][2]*s + C[k][1]*t
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sel_ga[k] = r_sq_row[0] ? cm[k][2] : cm[k][0];
            sel_gb[k] = r_sq_row[0] ? cm[k][1] : cm[k][2];
        end
    end

    // ---------------- stage 1 ----------------
    logic                 r1_valid;
    logic [2:0]           r1_row;
    logic signed [VW-1:0] r1_s, r1_t;
    logic signed [MW-1:0] r1_ga [3];
    logic signed [MW-1:0] r1_gb [3];
    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_d;
    logic [2:0][VW-1:0]   r1_pv, r1_uv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= r_sq_valid;
            r1_row   <= r_sq_row;
            r1_s     <= sel_s;
            r1_t     <= sel_t;
            r1_a     <= r_sq_a;
            r1_b     <= r_sq_b;
            r1_c     <= r_sq_c;
            r1_d     <= r_sq_d;
            for (int k = 0; k < 3; k++) begin
                r1_ga[k] <= sel_ga[k];
                r1_gb[k] <= sel_gb[k];
                r1_pv[k] <= pv[k];
                r1_uv[k] <= uv[k];
            end
        end
    end

    // ---------------- multiply group 1: C*e and determinant ----------------
    logic signed [MW+VW-1:0] p_ga [3];
    logic signed [MW+VW-1:0] p_gb [3];
    logic signed [2*DW-1:0]  p_ad, p_bc;

    for (genvar k = 0; k < 3; k++) begin : g_mul1
        tes_smul #(.AW(MW), .BW(VW)) u_ga (
            .i_clk(i_clk), .i_en(en), .i_a(r1_ga[k]), .i_b(r1_s), .o_p(p_ga[k]));
        tes_smul #(.AW(MW), .BW(VW)) u_gb (
            .i_clk(i_clk), .i_en(en), .i_a(r1_gb[k]), .i_b(r1_t), .o_p(p_gb[k]));
    end

    tes_smul #(.AW(DW), .BW(DW)) u_ad (
        .i_clk(i_clk), .i_en(en), .i_a(r1_a), .i_b(r1_d), .o_p(p_ad));
    tes_smul #(.AW(DW), .BW(DW)) u_bc (
        .i_clk(i_clk), .i_en(en), .i_a(r1_b), .i_b(r1_c), .o_p(p_bc));

    t_m1 r_m1 [ML];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ML; i++) r_m1[i].valid <= 1'b0;
        end else if (en) begin
            r_m1[0] <= '{valid: r1_valid, row: r1_row, pv: r1_pv, uv: r1_uv};
            for (int i = 1; i < ML; i++) r_m1[i] <= r_m1[i-1];
        end
    end

    // ---------------- stage 2 ----------------
    logic                   r2_valid;
    logic [2:0]             r2_row;
    logic signed [GW-1:0]   r2_g [3];
    logic signed [DETW-1:0] r2_det;
    logic [2:0][VW-1:0]     r2_pv, r2_uv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r_m1[ML-1].valid;
            r2_row   <= r_m1[ML-1].row;
            r2_pv    <= r_m1[ML-1].pv;
            r2_uv    <= r_m1[ML-1].uv;
            r2_det   <= DETW'(p_ad) - DETW'(p_bc);
            for (int k = 0; k < 3; k++) begin
                r2_g[k] <= GW'(p_ga[k]) + GW'(p_gb[k]);
            end
        end
    end

    // ---------------- multiply group 2: e_j' * g per column ----------------
    logic signed [VW+GW-1:0] x1p [6];
    logic signed [VW+GW-1:0] x2p [6];

    for (genvar j = 0; j < 6; j++) begin : g_mul2
        if (j % 2 == 0) begin : g_even
            tes_smul #(.AW(VW), .BW(GW)) u_m1 (
                .i_clk(i_clk), .i_en(en), .i_a($signed(r2_pv[j/2])), .i_b(r2_g[0]),
                .o_p(x1p[j]));
            tes_smul #(.AW(VW), .BW(GW)) u_m2 (
                .i_clk(i_clk), .i_en(en), .i_a($signed(r2_uv[j/2])), .i_b(r2_g[2]),
                .o_p(x2p[j]));
        end else begin : g_odd
            tes_smul #(.AW(VW), .BW(GW)) u_m1 (
                .i_clk(i_clk), .i_en(en), .i_a($signed(r2_uv[j/2])), .i_b(r2_g[1]),
                .o_p(x1p[j]));
            tes_smul #(.AW(VW), .BW(GW)) u_m2 (
                .i_clk(i_clk), .i_en(en), .i_a($signed(r2_pv[j/2])), .i_b(r2_g[2]),
                .o_p(x2p[j]));
        end
    end

    t_m2 r_m2 [ML];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ML; i++) r_m2[i].valid <= 1'b0;
        end else if (en) begin
            r_m2[0] <= '{valid: r2_valid, row: r2_row, det: r2_det};
            for (int i = 1; i < ML; i++) r_m2[i] <= r_m2[i-1];
        end
    end

    // ---------------- stage 3 ----------------
    logic                 r3_valid;
    logic [2:0]           r3_row;
    logic                 r3_zero;
    logic [DETW-1:0]      r3_absd;
    logic signed [KW-1:0] r3_k [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r_m2[ML-1].valid;
            r3_row   <= r_m2[ML-1].row;
            r3_zero  <= r_m2[ML-1].det == '0;
            r3_absd  <= r_m2[ML-1].det[DETW-1] ? DETW'(-r_m2[ML-1].det)
                                                : DETW'(r_m2[ML-1].det);
            for (int j = 0; j < 6; j++) begin
                r3_k[j] <= KW'(x1p[j]) + KW'(x2p[j]);
            end
        end
    end

    // ---------------- multiply group 3: thickness scaling ----------------
    logic signed [TW:0]     thick_s;
    logic signed [TW+KW:0]  n_prod [6];

    assign thick_s = $signed({1'b0, r_thick});

    for (genvar j = 0; j < 6; j++) begin : g_mul3
        tes_smul #(.AW(TW + 1), .BW(KW)) u_th (
            .i_clk(i_clk), .i_en(en), .i_a(thick_s), .i_b(r3_k[j]), .o_p(n_prod[j]));
    end

    t_m3 r_m3 [ML];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ML; i++) r_m3[i].valid <= 1'b0;
        end else if (en) begin
            r_m3[0] <= '{valid: r3_valid, row: r3_row, zero: r3_zero, absd: r3_absd};
            for (int i = 1; i < ML; i++) r_m3[i] <= r_m3[i-1];
        end
    end

    // ---------------- stage 4: sign and magnitude ----------------
    logic              r4_valid;
    logic [2:0]        r4_row;
    logic              r4_zero;
    logic [DETW-1:0]   r4_absd;
    logic [5:0]        r4_neg;
    logic [NW-1:0]     r4_mag [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r_m3[ML-1].valid;
            r4_row   <= r_m3[ML-1].row;
            r4_zero  <= r_m3[ML-1].zero;
            r4_absd  <= r_m3[ML-1].absd;
            for (int j = 0; j < 6; j++) begin
                r4_neg[j] <= n_prod[j][NW-1];
                r4_mag[j] <= n_prod[j][NW-1] ? NW'(-n_prod[j]) : NW'(n_prod[j]);
            end
        end
    end

    // ---------------- stage 5: rounding offset and divisor ----------------
    // result = (|n| + |D|*2^F) / (|D|*2^(F+1)), rounds half away from zero
    logic [UW-1:0]   half_w;
    logic [DENW-1:0] den_w;
    logic            r5_valid;
    logic [2:0]      r5_row;
    logic            r5_zero;
    logic [5:0]      r5_neg;
    logic [UW-1:0]   r5_num [6];
    logic [DENW-1:0] r5_den;

    assign half_w = UW'(r4_absd) << FRAC_BITS;
    assign den_w  = DENW'(r4_absd) << (FRAC_BITS + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
            r5_row   <= r4_row;
            r5_zero  <= r4_zero;
            r5_neg   <= r4_neg;
            r5_den   <= den_w;
            for (int j = 0; j < 6; j++) begin
                r5_num[j] <= UW'(r4_mag[j]) + half_w;
            end
        end
    end

    // ---------------- divider lanes, one per column ----------------
    logic [EW-1:0] q [6];
    logic [5:0]    ovf;

    for (genvar j = 0; j < 6; j++) begin : g_div
        tes_div #(.DENW(DENW), .NUMW(UW)) u_div (
            .i_clk(i_clk), .i_en(en), .i_num(r5_num[j]), .i_den(r5_den),
            .o_q(q[j]), .o_ovf(ovf[j]));
    end

    t_md r_md [DL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DL; i++) r_md[i].valid <= 1'b0;
        end else if (en) begin
            r_md[0] <= '{valid: r5_valid, row: r5_row, zero: r5_zero, neg: r5_neg};
            for (int i = 1; i < DL; i++) r_md[i] <= r_md[i-1];
        end
    end

    // ---------------- output register: saturation ----------------
    localparam logic [EW-1:0] SAT_POS = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] SAT_NEG = {1'b1, {(EW-1){1'b0}}};

    logic          r_out_valid;
    logic [2:0]    r_out_row;
    logic          r_out_zero;
    logic [EW-1:0] r_out_ent [6];
    logic [EW-1:0] n_ent [6];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            if (r_md[DL-1].zero) begin
                n_ent[j] = '0;
            end else if (r_md[DL-1].neg[j]) begin
                n_ent[j] = (ovf[j] || q[j] > SAT_NEG) ? SAT_NEG : EW'(-q[j]);
            end else begin
                n_ent[j] = (ovf[j] || q[j][EW-1]) ? SAT_POS : q[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_md[DL-1].valid;
            r_out_row   <= r_md[DL-1].row;
            r_out_zero  <= r_md[DL-1].zero;
            for (int j = 0; j < 6; j++) r_out_ent[j] <= n_ent[j];
        end
    end

    assign en = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = {r_out_zero, r_out_row};
    assign o_m_tlast  = r_out_row == tes_pkg::ROW_LAST;

    for (genvar j = 0; j < tes_pkg::ROWS; j++) begin : g_tdata
        assign o_m_tdata[j*EW +: EW] = r_out_ent[j];
    end

endmodule

@@ tb/tb_triangle_element_stiffness_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_element_stiffness_core
// Self-checking bench: drives triangle beats under several thickness and
// material settings, predicts each 6x6 stiffness matrix row by row in wide
// integer arithmetic and compares every output beat against it.
// ----------------------------------------------------------------------------
module tb_triangle_element_stiffness_core;

    localparam int          FB        = tes_pkg::FRAC_BITS_DEF;
    localparam int          CYC_LIMIT = 400000;
    localparam logic [2:0]  CFG_NONE  = 3'd7;   // unmapped index, must be ignored

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic [2:0]   row;
        logic [63:0]  entry [6];
        logic         degen;
        logic         last;
    } t_row_beat;

    typedef struct {
        logic [31:0] crd [6];   // x1 y1 x2 y2 x3 y3
        logic        zero_exp;  // expected rows typed in: all zero, degenerate
    } t_tri_vec;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [191:0]  i_s_tdata = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [383:0]  o_m_tdata;
    logic [3:0]    o_m_tuser;
    logic          o_m_tlast;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_idx = '0;
    logic [47:0]   i_cfg_wdata = '0;

    triangle_element_stiffness_core dut (.*);

    always #6 i_clk = ~i_clk;

    // shadow of the block's registers
    logic [31:0]        thick_sh;
    logic signed [47:0] mat_sh [6];

    t_row_beat row_fifo [$];
    int  n_err     = 0;
    int  beats_in  = 0;
    bit  idle_en   = 1'b1;
    bit  hold_done = 1'b0;
    int  cycles    = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch @%0t: %s got %h want %h", $realtime, what, got, want);
        n_err++;
    endtask

    // stiffness rows of one triangle, pushed onto row_fifo
    function automatic void stiffness_rows(input logic [31:0] crd [6]);
        t_wide x1, y1, x2, y2, x3, y3, a, b, c, d, det, absd, half, den, th;
        t_wide bn [3][6];
        t_wide cm [3][3];
        t_wide cb [3][6];
        t_wide s, n, q;
        t_wide pos_lim, neg_lim;
        int cidx [3][3];
        bit neg, degen;
        t_row_beat rb;
        cidx = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
        pos_lim = t_wide'(64'h7FFF_FFFF_FFFF_FFFF);
        neg_lim = t_wide'(64'h8000_0000_0000_0000);
        x1 = $signed(crd[0]); y1 = $signed(crd[1]);
        x2 = $signed(crd[2]); y2 = $signed(crd[3]);
        x3 = $signed(crd[4]); y3 = $signed(crd[5]);
        a = x2 - x1; b = y2 - y1; c = x3 - x1; d = y3 - y1;
        det = a * d - b * c;
        degen = (det == 0);
        absd = (det < 0) ? -det : det;
        half = absd <<< FB;
        den  = half + half;
        th   = {224'b0, thick_sh};
        foreach (bn[k, j]) bn[k][j] = 0;
        bn[0][0] = b - d; bn[0][2] = d; bn[0][4] = -b;
        bn[1][1] = c - a; bn[1][3] = -c; bn[1][5] = a;
        bn[2][0] = c - a; bn[2][1] = b - d; bn[2][2] = -c;
        bn[2][3] = d; bn[2][4] = a; bn[2][5] = -b;
        foreach (cm[k, l]) cm[k][l] = mat_sh[cidx[k][l]];
        foreach (cb[k, j]) begin
            cb[k][j] = 0;
            for (int l = 0; l < 3; l++) cb[k][j] += cm[k][l] * bn[l][j];
        end
        for (int i = 0; i < 6; i++) begin
            rb.row   = i[2:0];
            rb.degen = degen;
            rb.last  = (i == 5);
            for (int j = 0; j < 6; j++) begin
                if (degen) begin
                    rb.entry[j] = '0;
                end else begin
                    s = 0;
                    for (int k = 0; k < 3; k++) s += bn[k][i] * cb[k][j];
                    n = th * s;
                    neg = (n < 0);
                    if (neg) n = -n;
                    q = (n + half) / den;
                    if (neg) rb.entry[j] = (q > neg_lim) ? 64'h8000_0000_0000_0000 : 64'(-q);
                    else     rb.entry[j] = (q > pos_lim) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'(q);
                end
            end
            row_fifo.push_back(rb);
        end
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == tes_pkg::CFG_THICK)     thick_sh = val[31:0];
        else if (idx <= tes_pkg::CFG_C33)  mat_sh[idx - 1] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // drain, then let the pipeline empty out
    task automatic wait_idle();
        while (row_fifo.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // one triangle beat; valid stays high back to back unless a gap is drawn
    task automatic send_tri(input logic [31:0] crd [6], input bit zero_exp);
        t_row_beat rb;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {crd[5], crd[4], crd[3], crd[2], crd[1], crd[0]};
        do @(posedge i_clk); while (!o_s_tready);
        beats_in++;
        if (zero_exp) begin
            for (int i = 0; i < 6; i++) begin
                rb.row = i[2:0];
                foreach (rb.entry[j]) rb.entry[j] = '0;
                rb.degen = 1'b1;
                rb.last  = (i == 5);
                row_fifo.push_back(rb);
            end
        end else begin
            stiffness_rows(crd);
        end
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 2097151)) - 32'd1048576;
            default: return 32'($urandom_range(0, 255)) << 16;
        endcase
    endfunction

    task automatic random_tris(input int count);
        logic [31:0] crd [6];
        int mode;
        for (int t = 0; t < count; t++) begin
            mode = $urandom_range(0, 2);
            foreach (crd[i]) crd[i] = rand_coord(mode);
            // some collinear / coincident corners for the degenerate path
            if ($urandom_range(0, 9) == 0) begin
                crd[4] = crd[0]; crd[5] = crd[1];
            end else if ($urandom_range(0, 19) == 0) begin
                crd[4] = crd[2]; crd[5] = crd[3];
            end
            send_tri(crd, 1'b0);
        end
        i_s_tvalid <= 1'b0;
    endtask

    function automatic logic [47:0] rand_mat();
        case ($urandom_range(0, 3))
            0:       return 48'({$urandom, $urandom});
            1:       return 48'($urandom_range(0, 262143));
            2:       return -48'($urandom_range(0, 262143));
            default: return 48'($urandom_range(0, 65535)) << 8;
        endcase
    endfunction

    // ---------------- directed table ----------------
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE = 32'h0001_0000;

    t_tri_vec dir_tab [14] = '{
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1},       // all corners at origin
        '{'{32'd0, 32'd0, ONE, ONE, 32'h0002_0000, 32'h0002_0000}, 1'b1}, // collinear
        '{'{MX, MX, MX, MX, MX, MX}, 1'b1},                          // coincident at max
        '{'{MN, MN, MN, MN, MN, MN}, 1'b1},                          // coincident at min
        '{'{32'd0, 32'd0, ONE, 32'd0, 32'd0, ONE}, 1'b0},           // unit right triangle
        '{'{32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0}, 1'b0},           // negative determinant
        '{'{MN, MN, MX, MN, MN, MX}, 1'b0},                          // extreme span
        '{'{MX, MX, MN, MX, MX, MN}, 1'b0},
        '{'{MN, MX, MX, MN, MX, MX}, 1'b0},
        '{'{32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1}, 1'b0},       // tiny area, huge rows
        '{'{32'd0, 32'd0, MX, 32'd1, 32'd1, MX}, 1'b0},
        '{'{32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, ONE, ONE}, 1'b0},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 32'd0}, 1'b0},
        '{'{32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, MN, MX}, 1'b0}
    };

    // ---------------- result side ----------------
    int rdy_cnt  = 0;
    int hold_cnt = 0;

    always @(posedge i_clk) begin
        t_row_beat want;
        if (o_m_tvalid && i_m_tready) begin
            if (row_fifo.size() == 0) begin
                report("unexpected row beat", 64'(o_m_tuser), 64'd0);
            end else begin
                want = row_fifo.pop_front();
                if (o_m_tuser[2:0] !== want.row) report("row_index", 64'(o_m_tuser[2:0]), 64'(want.row));
                for (int j = 0; j < 6; j++)
                    if (o_m_tdata[j*64 +: 64] !== want.entry[j])
                        report($sformatf("row %0d col %0d", want.row, j),
                               o_m_tdata[j*64 +: 64], want.entry[j]);
                if (o_m_tuser[3] !== want.degen) report("degenerate", 64'(o_m_tuser[3]), 64'(want.degen));
                if (o_m_tlast !== want.last) report("tlast", 64'(o_m_tlast), 64'(want.last));
            end
        end
        // ready pattern: one long hold-off while the sender keeps pushing,
        // otherwise short random bursts, none near the end
        if (!hold_done && beats_in >= 40) begin
            hold_done <= 1'b1;
            hold_cnt  <= 400;
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_m_tready <= (hold_cnt == 1);
        end else if (!idle_en) begin
            i_m_tready <= 1'b1;
        end else if (rdy_cnt > 0) begin
            rdy_cnt <= rdy_cnt - 1;
        end else if (i_m_tready) begin
            i_m_tready <= 1'b0;
            rdy_cnt <= $urandom_range(0, 8);
        end else begin
            i_m_tready <= 1'b1;
            rdy_cnt <= $urandom_range(0, 20);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYC_LIMIT) begin
            $display("** triangle_element_stiffness_core: FAILED **");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        thick_sh = 32'd65536;
        mat_sh   = '{48'sd65536, 48'sd0, 48'sd0, 48'sd65536, 48'sd0, 48'sd32768};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset
        foreach (dir_tab[t]) send_tri(dir_tab[t].crd, dir_tab[t].zero_exp);
        i_s_tvalid <= 1'b0;
        wait_idle();

        // random material, long receiver hold-off lands in here
        cfg_write(tes_pkg::CFG_THICK, 48'($urandom));
        cfg_write(tes_pkg::CFG_C11, rand_mat());
        cfg_write(tes_pkg::CFG_C12, rand_mat());
        cfg_write(tes_pkg::CFG_C13, rand_mat());
        cfg_write(tes_pkg::CFG_C22, rand_mat());
        cfg_write(tes_pkg::CFG_C23, rand_mat());
        cfg_write(tes_pkg::CFG_C33, rand_mat());
        cfg_write(CFG_NONE, 48'hFFFF_FFFF_FFFF);
        random_tris(80);
        wait_idle();

        // extremes: max thickness, material at both limits
        cfg_write(tes_pkg::CFG_THICK, 48'h0000_FFFF_FFFF);
        cfg_write(tes_pkg::CFG_C11, 48'h7FFF_FFFF_FFFF);
        cfg_write(tes_pkg::CFG_C12, 48'h8000_0000_0000);
        cfg_write(tes_pkg::CFG_C13, 48'h7FFF_FFFF_FFFF);
        cfg_write(tes_pkg::CFG_C22, 48'h8000_0000_0000);
        cfg_write(tes_pkg::CFG_C23, 48'h8000_0000_0000);
        cfg_write(tes_pkg::CFG_C33, 48'h7FFF_FFFF_FFFF);
        random_tris(50);
        wait_idle();

        // zero thickness: every row zero, degenerate only where the corners make it so
        cfg_write(tes_pkg::CFG_THICK, 48'd0);
        random_tris(20);
        wait_idle();

        // a plain isotropic-like setting, then a random one without idling
        cfg_write(tes_pkg::CFG_THICK, 48'd32768);
        cfg_write(tes_pkg::CFG_C11, 48'd143360);
        cfg_write(tes_pkg::CFG_C12, 48'd43008);
        cfg_write(tes_pkg::CFG_C13, 48'd0);
        cfg_write(tes_pkg::CFG_C22, 48'd143360);
        cfg_write(tes_pkg::CFG_C23, 48'd0);
        cfg_write(tes_pkg::CFG_C33, 48'd50176);
        random_tris(60);
        wait_idle();

        for (int r = 0; r <= 6; r++) cfg_write(r[2:0], r == 0 ? 48'($urandom) : rand_mat());
        idle_en = 1'b0;
        random_tris(50);

        while (row_fifo.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_err == 0)
            $display("** triangle_element_stiffness_core: PASSED **");
        else
            $display("** triangle_element_stiffness_core: FAILED **");
        $finish;
    end

endmodule

@@ triangle_element_stiffness_core.f @@
src/tes_pkg.sv
src/tes_smul.sv
src/tes_div.sv
src/triangle_element_stiffness_core.sv
tb/tb_triangle_element_stiffness_core.sv
